[rtl/isort_pkg.sv]
// Package with the shared types and constants of the insertion sorter.
`timescale 1ns / 1ps

package isort_pkg;

   localparam int KEY_W = 32;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath cells.
   typedef struct packed {
      logic insert;   // insert the request key into the sorted row
      logic shift;    // move every cell down one place toward the head
   } cmd_type;

endpackage

[rtl/isort_req_if.sv]
// Request channel: key and block end mark with valid/ready handshake.
`timescale 1ns / 1ps

interface isort_req_if;
   logic                valid;
   logic                ready;
   isort_pkg::key_type  key;
   logic                block_end;

   modport source (output valid, output key, output block_end, input ready);
   modport sink   (input valid, input key, input block_end, output ready);
endinterface

[rtl/isort_rsp_if.sv]
// Response channel: sorted key with run end and overflow marks.
`timescale 1ns / 1ps

interface isort_rsp_if;
   logic                valid;
   logic                ready;
   isort_pkg::key_type  sorted_key;
   logic                run_end;
   logic                overflowed;

   modport source (output valid, output sorted_key, output run_end, output overflowed,
                   input ready);
   modport sink   (input valid, input sorted_key, input run_end, input overflowed,
                   output ready);
endinterface

[rtl/isort_datapath.sv]
// Row of key cells: parallel compare-and-shift insertion, shift-out toward the head.
`timescale 1ns / 1ps

module isort_datapath #(
   parameter int STORE_DEPTH = 16,
   parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
   input  logic                clock,
   input  isort_pkg::cmd_type  cmd,
   input  logic [CNT_W-1:0]    fill_count,
   input  isort_pkg::key_type  key_in,
   output isort_pkg::key_type  head_key
);

   isort_pkg::key_type cells_ff [STORE_DEPTH];
   isort_pkg::key_type cells_in [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] gt;

   genvar i;
   generate
      for (i = 0; i < STORE_DEPTH; i++) begin : g_cell
         // empty cells count as larger than any key
         assign gt[i] = (CNT_W'(i) >= fill_count) || (key_in < cells_ff[i]);

         always_comb begin
            cells_in[i] = cells_ff[i];
            if (cmd.shift) begin
               if (i < STORE_DEPTH - 1) begin
                  cells_in[i] = cells_ff[(i < STORE_DEPTH - 1) ? i + 1 : i];
               end
            end else if (cmd.insert && gt[i]) begin
               if (i == 0) begin
                  cells_in[i] = key_in;
               end else if (gt[(i > 0) ? i - 1 : 0]) begin
                  cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
               end else begin
                  cells_in[i] = key_in;
               end
            end
         end

         always_ff @(posedge clock) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   endgenerate

   assign head_key = cells_ff[0];

endmodule

[rtl/isort_ctrl.sv]
// Controller: load/emit state machine, fill count and overflow flag.
`timescale 1ns / 1ps

module isort_ctrl #(
   parameter int STORE_DEPTH = 16,
   parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_block_end,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_run_end,
   output logic                rsp_overflowed,
   output isort_pkg::cmd_type  cmd,
   output logic [CNT_W-1:0]    fill_count
);

   localparam logic [CNT_W-1:0] FULL = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   isort_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic                 ovf_ff, ovf_in;
   logic                 req_fire, rsp_fire, full;

   assign full     = (fill_ff == FULL);
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         isort_pkg::ST_LOAD: begin
            if (req_fire && req_block_end) begin
               state_in = isort_pkg::ST_EMIT;
            end
         end
         isort_pkg::ST_EMIT: begin
            if (rsp_fire && fill_ff == ONE) begin
               state_in = isort_pkg::ST_LOAD;
            end
         end
         default: state_in = isort_pkg::ST_LOAD;
      endcase
   end

   // outputs and counters
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      fill_in        = fill_ff;
      ovf_in         = ovf_ff;
      unique case (state_ff)
         isort_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd.insert = 1'b1;
                  fill_in    = fill_ff + ONE;
               end
            end
         end
         isort_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_fire) begin
               cmd.shift = 1'b1;
               fill_in   = fill_ff - ONE;
               if (fill_ff == ONE) begin
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_run_end    = (fill_ff == ONE);
   assign rsp_overflowed = ovf_ff;
   assign fill_count     = fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isort_pkg::ST_LOAD;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

[rtl/insertion_sorter.sv]
// Timing: an accepted request is inserted into the sorted row; the sorted block starts the
// cycle after the request marked block end, one response per cycle while rsp.ready is high.
// Throughput: one request per cycle while loading; no requests are taken while the
// block of N stored keys drains, set by the single shift-out row.
// Reset (synchronous, active high) empties the store and clears the overflow flag.
// Top level of the insertion sorter.
`timescale 1ns / 1ps

module insertion_sorter #(
   parameter int STORE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   isort_req_if.sink   req,
   isort_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   isort_pkg::cmd_type cmd;
   logic [CNT_W-1:0]   fill_count;

   isort_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_block_end  (req.block_end),
      .req_ready      (req.ready),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_run_end    (rsp.run_end),
      .rsp_overflowed (rsp.overflowed),
      .cmd            (cmd),
      .fill_count     (fill_count)
   );

   isort_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .CNT_W       (CNT_W)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .fill_count (fill_count),
      .key_in     (req.key),
      .head_key   (rsp.sorted_key)
   );

endmodule
